FILE: rtl/ledscan_pkg.sv
`timescale 1ns / 1ps

package ledscan_pkg;

    // Matrix geometry
    localparam int ROW_COUNT    = 12;
    localparam int COLUMN_COUNT = 20;

    // Field widths fixed by the port list
    localparam int CMD_W   = 3;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 5;
    localparam int MASK_W  = 20;
    localparam int PORT_W  = 8;
    localparam int BRIGHT_W = 7;

    // Frame store row index
    localparam int ROW_IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    // Row drive bits are always twelve wide on the expander
    localparam int ROW_DRIVE_W = 12;
    localparam logic [ROW_DRIVE_W-1:0] ROW_DRIVE_OFF = 12'hFFF;

    // Lit-column mask for the configured column count
    localparam logic [MASK_W-1:0] FULL_MASK = 20'hFFFFF;
    localparam logic [MASK_W-1:0] COL_MASK  = FULL_MASK >> (MASK_W - COLUMN_COUNT);

    // Blanking pattern FF 0F 00 00 00
    localparam logic [PORT_W-1:0] BLANK_PORT0 = 8'hFF;
    localparam logic [PORT_W-1:0] BLANK_PORT1 = 8'h0F;
    localparam logic [PORT_W-1:0] PORT_ZERO   = 8'h00;

    // Duty math: floor(255 * (100 - b) / 100)
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;
    localparam int DUTY_PROD_W = 15;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROW   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FILL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 3'd4;

    // Operations that survive classification
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_PIXEL,
        OP_ROW,
        OP_FILL,
        OP_SCAN
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [ROW_IDX_W-1:0] row;
        logic [COL_W-1:0]     column;
        logic                 pixel_on;
        logic [MASK_W-1:0]    row_mask;
    } t_cmd;

    typedef struct packed {
        logic              strobe;
        logic [PORT_W-1:0] port0;
        logic [PORT_W-1:0] port1;
        logic [PORT_W-1:0] port2;
        logic [PORT_W-1:0] port3;
        logic [PORT_W-1:0] port4;
        logic [ROW_W-1:0]  scanned_row;
        logic              is_blank;
        logic              last;
        logic [PORT_W-1:0] oe_duty;
    } t_result;

endpackage

FILE: rtl/ledscan_front.sv
`timescale 1ns / 1ps

module ledscan_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ledscan_pkg::CMD_W-1:0]  i_command,
    input  logic [ledscan_pkg::ROW_W-1:0]  i_row,
    input  logic [ledscan_pkg::COL_W-1:0]  i_column,
    input  logic                           i_pixel_on,
    input  logic [ledscan_pkg::MASK_W-1:0] i_row_mask,
    input  logic                           i_pop,
    output logic                           o_empty,
    output ledscan_pkg::t_cmd              o_cmd
);
    import ledscan_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_queue [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic accept;
    logic keep;
    t_cmd n_cmd;

    // Classify the incoming beat; drop unknown codes and out-of-range targets
    always_comb begin
        keep            = 1'b0;
        n_cmd.op        = OP_CLEAR;
        n_cmd.row       = i_row[ROW_IDX_W-1:0];
        n_cmd.column    = i_column;
        n_cmd.pixel_on  = i_pixel_on;
        n_cmd.row_mask  = i_row_mask & COL_MASK;
        unique case (i_command)
            CMD_CLEAR: begin
                keep     = 1'b1;
                n_cmd.op = OP_CLEAR;
            end
            CMD_PIXEL: begin
                keep     = (32'(i_row) < ROW_COUNT) && (32'(i_column) < COLUMN_COUNT);
                n_cmd.op = OP_PIXEL;
            end
            CMD_ROW: begin
                keep     = 32'(i_row) < ROW_COUNT;
                n_cmd.op = OP_ROW;
            end
            CMD_FILL: begin
                keep     = 1'b1;
                n_cmd.op = OP_FILL;
            end
            CMD_SCAN: begin
                keep     = 1'b1;
                n_cmd.op = OP_SCAN;
            end
            default: begin
                keep     = 1'b0;
                n_cmd.op = OP_CLEAR;
            end
        endcase
    end

    assign busy    = (r_count == 2'(DEPTH));
    assign accept  = start && !busy;
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_queue[r_rd_ptr];

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_queue[r_wr_ptr] <= n_cmd;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept && keep) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(accept && keep) - 2'(i_pop);
        end
    end

endmodule

FILE: rtl/ledscan_back.sv
`timescale 1ns / 1ps

module ledscan_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  ledscan_pkg::t_cmd                 i_cmd,
    output logic                              o_pop,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ledscan_pkg::BRIGHT_W-1:0]  i_cfg_data,
    output ledscan_pkg::t_result              o_result
);
    import ledscan_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_ROW
    } t_state;

    t_state                r_state;
    logic [MASK_W-1:0]     r_store [ROW_COUNT];
    logic [ROW_W-1:0]      r_scan_row;
    logic [PORT_W-1:0]     r_duty;
    t_result               r_result;

    logic [BRIGHT_W-1:0]                   sat;
    logic [BRIGHT_W-1:0]                   dim;
    logic [DUTY_PROD_W-1:0]                prod;
    logic [DUTY_PROD_W+RECIP_W-1:0]        scaled;
    logic [PORT_W-1:0]                     n_duty;
    logic [ROW_W-1:0]                      n_scan_row;
    logic [ROW_DRIVE_W-1:0]                row_drive;
    logic [MASK_W-1:0]                     lit;

    // Saturate brightness and turn it into the output-enable duty
    always_comb begin
        sat    = (i_cfg_data > BRIGHT_MAX) ? BRIGHT_MAX : i_cfg_data;
        dim    = BRIGHT_MAX - sat;
        prod   = {dim, 8'b0} - DUTY_PROD_W'(dim);
        scaled = (DUTY_PROD_W+RECIP_W)'(prod) * (DUTY_PROD_W+RECIP_W)'(RECIP_100);
        n_duty = scaled[RECIP_SHIFT +: PORT_W];
    end

    assign o_cfg_ready = 1'b1;

    // Hold the duty for every result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= PORT_ZERO;
        end else if (i_cfg_valid) begin
            r_duty <= n_duty;
        end
    end

    // Row pattern of the current scan row
    always_comb begin
        n_scan_row = (32'(r_scan_row) + 1 >= ROW_COUNT) ? '0 : r_scan_row + 4'd1;
        row_drive  = ROW_DRIVE_OFF & ~(ROW_DRIVE_W'(1) << r_scan_row);
        lit        = r_store[r_scan_row[ROW_IDX_W-1:0]] & COL_MASK;
    end

    assign o_pop    = (r_state == ST_RUN) && !i_empty;
    assign o_result = r_result;

    // Execute queued commands and drive results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_RUN;
            r_scan_row      <= '0;
            r_result.strobe <= 1'b0;
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_result.strobe <= 1'b0;
            unique case (r_state)
                ST_RUN: begin
                    if (!i_empty) begin
                        case (i_cmd.op)
                            OP_CLEAR: begin
                                for (int i = 0; i < ROW_COUNT; i++) begin
                                    r_store[i] <= '0;
                                end
                            end
                            OP_PIXEL: begin
                                r_store[i_cmd.row][i_cmd.column] <= i_cmd.pixel_on;
                            end
                            OP_ROW: begin
                                r_store[i_cmd.row] <= i_cmd.row_mask;
                            end
                            OP_FILL: begin
                                for (int i = 0; i < ROW_COUNT; i++) begin
                                    r_store[i] <= i_cmd.pixel_on ? COL_MASK : '0;
                                end
                            end
                            OP_SCAN: begin
                                // first beat: blanking pattern
                                r_result.strobe      <= 1'b1;
                                r_result.port0       <= BLANK_PORT0;
                                r_result.port1       <= BLANK_PORT1;
                                r_result.port2       <= PORT_ZERO;
                                r_result.port3       <= PORT_ZERO;
                                r_result.port4       <= PORT_ZERO;
                                r_result.scanned_row <= r_scan_row;
                                r_result.is_blank    <= 1'b1;
                                r_result.last        <= 1'b0;
                                r_result.oe_duty     <= r_duty;
                                r_state              <= ST_ROW;
                            end
                            default: begin
                                r_state <= ST_RUN;
                            end
                        endcase
                    end
                end
                ST_ROW: begin
                    // second beat: row pattern, then advance the row
                    r_result.strobe      <= 1'b1;
                    r_result.port0       <= row_drive[7:0];
                    r_result.port1       <= {lit[3:0], row_drive[11:8]};
                    r_result.port2       <= lit[11:4];
                    r_result.port3       <= lit[19:12];
                    r_result.port4       <= PORT_ZERO;
                    r_result.scanned_row <= r_scan_row;
                    r_result.is_blank    <= 1'b0;
                    r_result.last        <= 1'b1;
                    r_result.oe_duty     <= r_duty;
                    r_scan_row           <= n_scan_row;
                    r_state              <= ST_RUN;
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

endmodule

FILE: rtl/led_matrix_row_scanner.sv
`timescale 1ns / 1ps

// LED matrix row scanner. Commands enter on start while busy is low and go
// through a two-entry queue to the executing side. A write command is done
// there in ST_RUN; a scan tick passes ST_RUN and then ST_ROW and gives two
// beats on consecutive cycles, the blanking pattern then the row pattern,
// each marked by o_strobe for exactly one cycle. The receiver cannot hold
// beats off. The executing side takes one write per cycle in ST_RUN; in
// ST_ROW it pops nothing, so later commands wait for a scan's row beat.
// busy rises only when the queue is full. Results are registered. Brightness
// writes are always ready and apply to beats formed after the duty loads.
module led_matrix_row_scanner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ledscan_pkg::CMD_W-1:0]     i_command,
    input  logic [ledscan_pkg::ROW_W-1:0]     i_row,
    input  logic [ledscan_pkg::COL_W-1:0]     i_column,
    input  logic                              i_pixel_on,
    input  logic [ledscan_pkg::MASK_W-1:0]    i_row_mask,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ledscan_pkg::BRIGHT_W-1:0]  i_cfg_data,
    output logic                              o_strobe,
    output logic [ledscan_pkg::PORT_W-1:0]    o_port0,
    output logic [ledscan_pkg::PORT_W-1:0]    o_port1,
    output logic [ledscan_pkg::PORT_W-1:0]    o_port2,
    output logic [ledscan_pkg::PORT_W-1:0]    o_port3,
    output logic [ledscan_pkg::PORT_W-1:0]    o_port4,
    output logic [ledscan_pkg::ROW_W-1:0]     o_scanned_row,
    output logic                              o_is_blank,
    output logic                              o_last,
    output logic [ledscan_pkg::PORT_W-1:0]    o_oe_duty
);
    import ledscan_pkg::*;

    logic    pop;
    logic    empty;
    t_cmd    cmd;
    t_result result;

    ledscan_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_row      (i_row),
        .i_column   (i_column),
        .i_pixel_on (i_pixel_on),
        .i_row_mask (i_row_mask),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_cmd      (cmd)
    );

    ledscan_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    // Spread the result beat onto its ports
    assign o_strobe      = result.strobe;
    assign o_port0       = result.port0;
    assign o_port1       = result.port1;
    assign o_port2       = result.port2;
    assign o_port3       = result.port3;
    assign o_port4       = result.port4;
    assign o_scanned_row = result.scanned_row;
    assign o_is_blank    = result.is_blank;
    assign o_last        = result.last;
    assign o_oe_duty     = result.oe_duty;

endmodule
